// ===== hw/rtl/haptic_damping_torque_loop_top_defines.svh =====
// Assertion macros for the haptic damping torque loop.
`ifndef HAPTIC_DAMPING_TORQUE_LOOP_TOP_DEFINES_SVH
`define HAPTIC_DAMPING_TORQUE_LOOP_TOP_DEFINES_SVH

// same-cycle implication
`define HDTL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HDTL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/hdtl_pkg.sv =====
// Package: types, widths and coefficients of the haptic damping torque loop.
package hdtl_pkg;

	localparam int ANGLE_BITS = 12;
	localparam int POLE_PAIRS = 7;
	localparam int ANGLE_COUNT = 2 ** ANGLE_BITS;
	localparam int HALF_TURN = ANGLE_COUNT / 2;

	localparam int TORQUE_W = 16;
	localparam int LIMIT_W = 15;
	localparam int GAIN_W = 16;
	localparam int SPEED_W = 24;
	localparam int DIFF_W = ANGLE_BITS + 1;
	localparam int VEL_FRAC = 8;
	localparam int X_W = DIFF_W + VEL_FRAC;
	localparam int MPLIER_W = 16;
	localparam int MCAND_W = SPEED_W;
	localparam int PROD_W = MCAND_W + MPLIER_W;
	localparam int SUM_W = PROD_W + 1;
	localparam int CNT_W = $clog2(MPLIER_W);
	localparam int FILT_SH = 16;
	localparam int TORQUE_SH = 4;
	localparam int TORQUE_MAX = 2 ** (TORQUE_W - 1) - 1;
	localparam int TORQUE_MIN = -(2 ** (TORQUE_W - 1));

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W = APB_ADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_MODE = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_GAIN = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_LIMIT = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_OFFSET = REG_IDX_W'(3);

	localparam logic MODE_NEG_FB = 1'b0;
	localparam logic MODE_POS_FB = 1'b1;

	localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(256);
	localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(10240);

	// filter weights, Q0.16
	localparam logic [MPLIER_W-1:0] K_V_OLD = MPLIER_W'(52429);
	localparam logic [MPLIER_W-1:0] K_V_NEW = MPLIER_W'(13107);
	localparam logic [MPLIER_W-1:0] K_DP_OLD = MPLIER_W'(62259);
	localparam logic [MPLIER_W-1:0] K_DP_NEW = MPLIER_W'(3277);
	localparam logic [MPLIER_W-1:0] K_SM_OLD = MPLIER_W'(60293);
	localparam logic [MPLIER_W-1:0] K_SM_NEW = MPLIER_W'(5243);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_POST,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		PH_VOLD,
		PH_XNEW,
		PH_GAIN,
		PH_SOLD,
		PH_TNEW
	} phase_t;

endpackage

// ===== hw/rtl/haptic_damping_torque_loop_top.sv =====
// Haptic damping torque loop: angle to velocity, filtered torque and electrical angle.
//
// One angle sample in, one result out. The first sample after reset or after a
// mode register write skips the multiplier and goes straight to the output register.
// Every later sample runs five products (velocity filter, gain, torque smoothing)
// one after another through a single bit-serial shift-add multiplier, each with a
// load step, one multiplier bit per cycle and a step to accumulate, round and clamp;
// then the output register is loaded. No new sample is taken until the output
// register is loaded, and a finished result waits in the output register while
// the next sample is taken.
`include "haptic_damping_torque_loop_top_defines.svh"

module haptic_damping_torque_loop_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [hdtl_pkg::APB_ADDR_W-1:0]       paddr,
	input  logic [hdtl_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [hdtl_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                  pready,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [hdtl_pkg::ANGLE_BITS-1:0]       angle_sample,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [hdtl_pkg::TORQUE_W-1:0]  torque_cmd,
	output logic [hdtl_pkg::ANGLE_BITS-1:0]       elec_angle
);
	import hdtl_pkg::*;

	localparam logic [ANGLE_BITS-1:0] PP_A = ANGLE_BITS'(POLE_PAIRS);
	localparam logic signed [DIFF_W-1:0] HALF_D = DIFF_W'(HALF_TURN);
	localparam logic signed [DIFF_W-1:0] NHALF_D = -HALF_D;
	localparam logic [DIFF_W-1:0] TURN_D = DIFF_W'(ANGLE_COUNT);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MPLIER_W - 1);
	localparam logic signed [SUM_W-1:0] RND_FILT = SUM_W'(2 ** (FILT_SH - 1));
	localparam logic signed [PROD_W-1:0] RND_TQ = PROD_W'(2 ** (TORQUE_SH - 1));
	localparam logic signed [SUM_W-1:0] S_MAX = SUM_W'(TORQUE_MAX);
	localparam logic signed [SUM_W-1:0] S_MIN = SUM_W'(TORQUE_MIN);

	state_t state_q, state_d;
	phase_t ph_q, ph_next;

	logic                          mode_q;
	logic [GAIN_W-1:0]             gain_q;
	logic [LIMIT_W-1:0]            limit_q;
	logic [ANGLE_BITS-1:0]         offset_q;

	logic [ANGLE_BITS-1:0]         last_q;
	logic                          have_last_q;
	logic signed [DIFF_W-1:0]      d_q;
	logic [ANGLE_BITS-1:0]         elec_hold_q;
	logic signed [SPEED_W-1:0]     speed_q;
	logic signed [TORQUE_W-1:0]    smooth_q;
	logic signed [TORQUE_W-1:0]    torque_t_q;
	logic signed [PROD_W-1:0]      acc_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic signed [MCAND_W-1:0]     mcand_q;
	logic [MPLIER_W-1:0]           mplier_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          out_valid_q;
	logic signed [TORQUE_W-1:0]    torque_out_q;
	logic [ANGLE_BITS-1:0]         elec_out_q;

	logic                          cfg_wr;
	logic [REG_IDX_W-1:0]          reg_idx;
	logic                          mode_wr;
	logic                          in_acc;
	logic                          out_load;
	logic signed [DIFF_W-1:0]      diff_raw;
	logic signed [DIFF_W-1:0]      diff_w;
	logic [ANGLE_BITS-1:0]         elec_d;
	logic signed [X_W-1:0]         x_val;
	logic signed [MCAND_W-1:0]     mcand_d;
	logic [MPLIER_W-1:0]           mplier_d;
	logic signed [PROD_W-1:0]      mcand_ext;
	logic signed [PROD_W-1:0]      acc_step;
	logic signed [SUM_W-1:0]       sum_all;
	logic signed [SUM_W-1:0]       filt_full;
	logic signed [PROD_W-1:0]      t_rnd;
	logic signed [PROD_W-1:0]      t_sgn;
	logic signed [PROD_W-1:0]      lim_p;
	logic signed [PROD_W-1:0]      t_clamp;
	logic signed [TORQUE_W-1:0]    s_clamp;
	logic signed [TORQUE_W-1:0]    lim_t;

	// config port
	assign pready = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign cfg_wr = psel && penable && pwrite && pready;
	assign mode_wr = cfg_wr && (reg_idx == REG_MODE);

	always_comb begin
		case (reg_idx)
			REG_MODE:   prdata = APB_DATA_W'(mode_q);
			REG_GAIN:   prdata = APB_DATA_W'(gain_q);
			REG_LIMIT:  prdata = APB_DATA_W'(limit_q);
			REG_OFFSET: prdata = APB_DATA_W'(offset_q);
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NEG_FB;
			gain_q <= GAIN_RST;
			limit_q <= LIMIT_RST;
			offset_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_MODE:   mode_q <= pwdata[0];
				REG_GAIN:   gain_q <= pwdata[GAIN_W-1:0];
				REG_LIMIT:  limit_q <= pwdata[LIMIT_W-1:0];
				REG_OFFSET: offset_q <= pwdata[ANGLE_BITS-1:0];
				default:    ;
			endcase
		end
	end

	// handshake
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign torque_cmd = torque_out_q;
	assign elec_angle = elec_out_q;

	// wrapped difference and electrical angle
	always_comb begin
		diff_raw = $signed({1'b0, angle_sample}) - $signed({1'b0, last_q});
		if (diff_raw > HALF_D) begin
			diff_w = diff_raw - TURN_D;
		end else if (diff_raw < NHALF_D) begin
			diff_w = diff_raw + TURN_D;
		end else begin
			diff_w = diff_raw;
		end
		elec_d = angle_sample * PP_A - offset_q;
	end

	// operand select per phase
	assign x_val = {d_q, {VEL_FRAC{1'b0}}};

	always_comb begin
		case (ph_q)
			PH_VOLD: begin
				mcand_d = speed_q;
				mplier_d = K_V_OLD;
				ph_next = PH_XNEW;
			end
			PH_XNEW: begin
				mcand_d = MCAND_W'(x_val);
				mplier_d = K_V_NEW;
				ph_next = PH_GAIN;
			end
			PH_GAIN: begin
				mcand_d = speed_q;
				mplier_d = gain_q;
				ph_next = PH_SOLD;
			end
			PH_SOLD: begin
				mcand_d = MCAND_W'(smooth_q);
				mplier_d = (mode_q == MODE_POS_FB) ? K_SM_OLD : K_DP_OLD;
				ph_next = PH_TNEW;
			end
			PH_TNEW: begin
				mcand_d = MCAND_W'(torque_t_q);
				mplier_d = (mode_q == MODE_POS_FB) ? K_SM_NEW : K_DP_NEW;
				ph_next = PH_VOLD;
			end
			default: begin
				mcand_d = speed_q;
				mplier_d = '0;
				ph_next = PH_VOLD;
			end
		endcase
	end

	// shift-add step, multiplier MSB first
	assign mcand_ext = PROD_W'(mcand_q);
	assign acc_step = (acc_q <<< 1) + (mplier_q[MPLIER_W-1] ? mcand_ext : {PROD_W{1'b0}});

	// accumulate, round, clamp
	always_comb begin
		sum_all = sum_q + SUM_W'(acc_q) + RND_FILT;
		filt_full = sum_all >>> FILT_SH;
		if (filt_full > S_MAX) begin
			s_clamp = TORQUE_W'(TORQUE_MAX);
		end else if (filt_full < S_MIN) begin
			s_clamp = TORQUE_W'(TORQUE_MIN);
		end else begin
			s_clamp = filt_full[TORQUE_W-1:0];
		end
		t_rnd = (acc_q + RND_TQ) >>> TORQUE_SH;
		t_sgn = (mode_q == MODE_NEG_FB) ? -t_rnd : t_rnd;
		lim_p = PROD_W'({1'b0, limit_q});
		if (t_sgn > lim_p) begin
			t_clamp = lim_p;
		end else if (t_sgn < -lim_p) begin
			t_clamp = -lim_p;
		end else begin
			t_clamp = t_sgn;
		end
	end

	assign lim_t = {1'b0, limit_q};

	// FSM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = have_last_q ? ST_LOAD : ST_OUT;
				end
			end
			ST_LOAD: state_d = ST_MUL;
			ST_MUL: begin
				if (cnt_q == CNT_LAST) begin
					state_d = ST_POST;
				end
			end
			ST_POST: state_d = (ph_q == PH_TNEW) ? ST_OUT : ST_LOAD;
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// loop state and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_VOLD;
			cnt_q <= '0;
			last_q <= '0;
			have_last_q <= 1'b0;
			speed_q <= '0;
			smooth_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (mode_wr) begin
				have_last_q <= 1'b0;
				speed_q <= '0;
				smooth_q <= '0;
			end else begin
				if (in_acc) begin
					last_q <= angle_sample;
					have_last_q <= 1'b1;
				end
				if (state_q == ST_POST) begin
					case (ph_q)
						PH_XNEW: speed_q <= filt_full[SPEED_W-1:0];
						PH_TNEW: smooth_q <= s_clamp;
						default: ;
					endcase
				end
			end
			if (in_acc) begin
				ph_q <= PH_VOLD;
			end else if (state_q == ST_POST) begin
				ph_q <= ph_next;
			end
			if (state_q == ST_LOAD) begin
				cnt_q <= '0;
			end else if (state_q == ST_MUL) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			d_q <= diff_w;
			elec_hold_q <= elec_d;
		end
		case (state_q)
			ST_LOAD: begin
				mcand_q <= mcand_d;
				mplier_q <= mplier_d;
				acc_q <= '0;
			end
			ST_MUL: begin
				acc_q <= acc_step;
				mplier_q <= mplier_q << 1;
			end
			ST_POST: begin
				case (ph_q)
					PH_VOLD, PH_SOLD: sum_q <= SUM_W'(acc_q);
					PH_GAIN:          torque_t_q <= t_clamp[TORQUE_W-1:0];
					default:          ;
				endcase
			end
			default: ;
		endcase
		if (out_load) begin
			torque_out_q <= smooth_q;
			elec_out_q <= elec_hold_q;
		end
	end

	`HDTL_ASSERT_NXT(a_first_sample_short, in_acc && !have_last_q, state_q == ST_OUT,
		"first sample did not go straight to output")
	`HDTL_ASSERT_NXT(a_start_phase, in_acc && have_last_q,
		state_q == ST_LOAD && ph_q == PH_VOLD, "sample did not start at first product")
	`HDTL_ASSERT_NXT(a_last_phase_out, state_q == ST_POST && ph_q == PH_TNEW,
		state_q == ST_OUT, "last product did not lead to output")
	`HDTL_ASSERT_NXT(a_torque_clamped, state_q == ST_POST && ph_q == PH_GAIN,
		torque_t_q <= lim_t && torque_t_q >= -lim_t, "torque outside limit")

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the haptic damping torque loop: directed and random angle streams.
module tb;
	import hdtl_pkg::*;

	localparam int LOOP_LATENCY = 92;
	localparam int DRAIN_PAUSE = LOOP_LATENCY + 8;
	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int WALK_PHASES = 7;
	localparam int WALK_ITEMS = 190;
	localparam int IDLE_PCT = 36;

	typedef struct packed {
		logic signed [TORQUE_W-1:0] torque;
		logic [ANGLE_BITS-1:0]      elec;
	} drive_cmd_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [APB_ADDR_W-1:0]         paddr = '0;
	logic [APB_DATA_W-1:0]         pwdata = '0;
	logic [APB_DATA_W-1:0]         prdata;
	logic                          pready;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [ANGLE_BITS-1:0]         angle_sample = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic signed [TORQUE_W-1:0]    torque_cmd;
	logic [ANGLE_BITS-1:0]         elec_angle;

	// register shadow and loop state
	logic                  m_mode = MODE_NEG_FB;
	logic [GAIN_W-1:0]     m_gain = 16'd256;
	logic [LIMIT_W-1:0]    m_limit = 15'd10240;
	logic [ANGLE_BITS-1:0] m_offset = '0;
	logic [ANGLE_BITS-1:0] m_last = '0;
	logic                  m_have = 1'b0;
	longint                m_speed = 0;
	longint                m_torque = 0;

	drive_cmd_t pending_cmds[$];
	int src_gap_pct = IDLE_PCT;
	int sink_stall_pct = IDLE_PCT;
	int hold_requests = 0;
	int errors = 0;
	int samples_sent = 0;
	int cmds_checked = 0;
	int reg_writes = 0;

	haptic_damping_torque_loop_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .angle_sample(angle_sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.torque_cmd(torque_cmd), .elec_angle(elec_angle)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic longint round_shr(input longint v, input int sh);
		return (v + (longint'(1) <<< (sh - 1))) >>> sh;
	endfunction

	function automatic drive_cmd_t advance_knob(input logic [ANGLE_BITS-1:0] angle);
		drive_cmd_t c;
		longint d, x, t, s, lim;
		if (m_have) begin
			d = longint'(angle) - longint'(m_last);
			if (d > HALF_TURN)
				d -= ANGLE_COUNT;
			else if (d < -HALF_TURN)
				d += ANGLE_COUNT;
			x = d * 256;
			m_speed = round_shr(52429 * m_speed + 13107 * x, 16);
			t = round_shr(longint'(m_gain) * m_speed, 4);
			if (m_mode == MODE_NEG_FB)
				t = -t;
			lim = longint'(m_limit);
			if (t > lim)
				t = lim;
			else if (t < -lim)
				t = -lim;
			if (m_mode == MODE_NEG_FB)
				s = round_shr(62259 * m_torque + 3277 * t, 16);
			else
				s = round_shr(60293 * m_torque + 5243 * t, 16);
			if (s > 32767)
				s = 32767;
			else if (s < -32768)
				s = -32768;
			m_torque = s;
		end
		m_last = angle;
		m_have = 1'b1;
		c.torque = m_torque[TORQUE_W-1:0];
		c.elec = ANGLE_BITS'(int'(angle) * POLE_PAIRS - int'(m_offset));
		return c;
	endfunction

	// result side: random stall, long hold-off on request, compare each transfer
	always @(posedge clk) begin
		int hold_served;
		int hold_left;
		drive_cmd_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				cmds_checked++;
				if (pending_cmds.size() == 0) begin
					$error("unexpected result: torque_cmd %0d elec_angle %0d",
						torque_cmd, elec_angle);
					errors++;
				end else begin
					e = pending_cmds.pop_front();
					if (torque_cmd !== e.torque) begin
						$error("torque_cmd: expected %0d, actual %0d", e.torque, torque_cmd);
						errors++;
					end
					if (elec_angle !== e.elec) begin
						$error("elec_angle: expected %0d, actual %0d", e.elec, elec_angle);
						errors++;
					end
				end
			end
		end
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		int quiet;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(psel && penable && pready)) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= WATCHDOG_LIMIT) begin
					$display("TB_ERROR");
					$finish;
				end
			end
		end
	end

	task automatic send_angle(input logic [ANGLE_BITS-1:0] a);
		if ($urandom_range(99) < src_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		angle_sample <= a;
		do @(posedge clk); while (!(in_valid && !in_stall));
		pending_cmds.push_back(advance_knob(a));
		samples_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	// write, then read back
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] raw);
		logic [APB_DATA_W-1:0] rb;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= raw;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rb = '0;
		case (idx)
			REG_MODE: begin
				m_mode = raw[0];
				m_have = 1'b0;
				m_speed = 0;
				m_torque = 0;
				rb[0] = m_mode;
			end
			REG_GAIN: begin
				m_gain = raw[GAIN_W-1:0];
				rb[GAIN_W-1:0] = m_gain;
			end
			REG_LIMIT: begin
				m_limit = raw[LIMIT_W-1:0];
				rb[LIMIT_W-1:0] = m_limit;
			end
			default: begin
				m_offset = raw[ANGLE_BITS-1:0];
				rb[ANGLE_BITS-1:0] = m_offset;
			end
		endcase
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== rb) begin
			$error("prdata reg %0d: expected %0h, actual %0h", idx, rb, prdata);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		reg_writes++;
	endtask

	task automatic test_first_sample_after_reset();
		send_angle(12'd1000);
		send_angle(12'd1010);
		send_angle(12'd1030);
		wait_idle();
	endtask

	task automatic test_half_turn_wrap();
		write_reg(REG_GAIN, 32'h1000);
		write_reg(REG_LIMIT, 32'h7FFF);
		write_reg(REG_MODE, {31'b0, MODE_POS_FB});
		send_angle(12'd0);
		send_angle(12'd2048);
		send_angle(12'd0);
		send_angle(12'd4095);
		send_angle(12'd0);
		send_angle(12'd2049);
		send_angle(12'd2047);
		wait_idle();
	endtask

	task automatic test_register_extremes();
		write_reg(REG_GAIN, 32'hFFFF);
		write_reg(REG_LIMIT, 32'h0);
		send_angle(12'd100);
		send_angle(12'd900);
		wait_idle();
		write_reg(REG_LIMIT, 32'h7FFF);
		write_reg(REG_OFFSET, 32'hFFF);
		write_reg(REG_MODE, {31'b0, MODE_NEG_FB});
		send_angle(12'd0);
		send_angle(12'd4095);
		send_angle(12'd0);
		wait_idle();
		write_reg(REG_GAIN, 32'h0);
		send_angle(12'd3000);
		send_angle(12'd1000);
		wait_idle();
	endtask

	// same mode value again still restarts the loop
	task automatic test_mode_rewrite();
		write_reg(REG_GAIN, 32'h0300);
		write_reg(REG_MODE, {31'b0, MODE_NEG_FB});
		send_angle(12'd500);
		send_angle(12'd520);
		wait_idle();
	endtask

	task automatic test_output_backpressure();
		src_gap_pct = 0;
		hold_requests++;
		for (int n = 0; n < 10; n++)
			send_angle(ANGLE_BITS'($urandom));
		wait_idle();
		src_gap_pct = IDLE_PCT;
	endtask

	task automatic test_random_walks();
		logic [ANGLE_BITS-1:0] cur;
		int amp;
		int g, l, o;
		for (int ph = 0; ph < WALK_PHASES; ph++) begin
			case (ph)
				1: g = 65535;
				4: g = 0;
				6: g = $urandom_range(0, 65535);
				default: g = $urandom_range(0, 2048);
			endcase
			case (ph)
				1: l = 32767;
				2: l = 0;
				default: l = $urandom_range(0, 32767);
			endcase
			o = (ph == 5) ? 4095 : $urandom_range(0, 4095);
			write_reg(REG_GAIN, {16'($urandom), 16'(g)});
			write_reg(REG_LIMIT, {17'($urandom), 15'(l)});
			write_reg(REG_OFFSET, {20'($urandom), 12'(o)});
			if (ph != 3)
				write_reg(REG_MODE, {31'($urandom), (ph % 2) ? MODE_POS_FB : MODE_NEG_FB});
			src_gap_pct = (ph == 2) ? 0 : IDLE_PCT;
			sink_stall_pct = (ph == 2) ? 0 : IDLE_PCT;
			case (ph % 4)
				0: amp = 2;
				1: amp = 16;
				2: amp = 128;
				default: amp = 2047;
			endcase
			cur = ANGLE_BITS'($urandom);
			for (int n = 0; n < WALK_ITEMS; n++) begin
				if ($urandom_range(99) < 8)
					cur = ANGLE_BITS'($urandom);
				else
					cur = ANGLE_BITS'(int'(cur) + $urandom_range(0, 2 * amp) - amp);
				send_angle(cur);
			end
			wait_idle();
		end
		src_gap_pct = IDLE_PCT;
		sink_stall_pct = IDLE_PCT;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_first_sample_after_reset();
		test_half_turn_wrap();
		test_register_extremes();
		test_mode_rewrite();
		test_output_backpressure();
		test_random_walks();
		wait_idle();
		$display("Run covered %0d angle samples and %0d register writes in both modes,",
			samples_sent, reg_writes);
		$display("with half-turn wraps, limit and gain extremes; %0d results checked, %0d errors.",
			cmds_checked, errors);
		if (errors == 0 && pending_cmds.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
